[rtl/stepper_ramp_period_generator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stepper ramp period generator
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_RAMP_PERIOD_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_PERIOD_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srpg assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SRPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srpg assertion failed");

`endif

[rtl/srpg_pkg.sv]
// ----------------------------------------------------------------------------
// srpg_pkg
// Widths, register indexes and shared types of the ramp period generator.
// ----------------------------------------------------------------------------
`default_nettype none

package srpg_pkg;

  localparam int unsigned INDEX_WIDTH  = 24;
  localparam int unsigned PERIOD_WIDTH = 32;
  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 4;

  // divisor 4n+1 / 4n-1 and the remainder both fit INDEX_WIDTH+1 bits
  localparam int unsigned DIV_W = INDEX_WIDTH + 1;
  // dividend 2c +/- r
  localparam int unsigned DVD_W = ((PERIOD_WIDTH > DIV_W) ? PERIOD_WIDTH : DIV_W) + 2;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [1:0] {
    REG_FIRST = 2'd0,
    REG_IDLE  = 2'd1,
    REG_EXACT = 2'd2
  } reg_idx_e;

endpackage

`default_nettype wire

[rtl/srpg_div.sv]
// ----------------------------------------------------------------------------
// srpg_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stepper_ramp_period_generator_macros.svh"

module srpg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [srpg_pkg::DVD_W-1:0]  dividend_i,
  input  logic [srpg_pkg::DIV_W-1:0]  divisor_i,
  output srpg_pkg::div_status_t       status_o,
  output logic [srpg_pkg::DVD_W-1:0]  quotient_o,
  output logic [srpg_pkg::DIV_W-1:0]  remainder_o
);
  import srpg_pkg::*;

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DIV_W-1:0] rem_q, dvs_q;
  logic [DIV_W:0]   trial, diff;
  logic             fits;

  // shift the next dividend bit into the partial remainder and try the divisor
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end
    end
  end

  // quotient bits enter at the bottom as dividend bits leave at the top
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end else if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = dvd_q;
  assign remainder_o   = rem_q;

  `SRPG_ASSERT_SAME(a_done_not_busy, clk_i, rst_ni, done_q, !busy_q)
  `SRPG_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_q, busy_q)
  `SRPG_ASSERT_SAME(a_rem_below_dvs, clk_i, rst_ni, done_q && (dvs_q != '0), rem_q < dvs_q)

endmodule

`default_nettype wire

[rtl/stepper_ramp_period_generator.sv]
// ----------------------------------------------------------------------------
// stepper_ramp_period_generator
// Linear-ramp step period limiter with a signed ramp index and carried remainder.
// ----------------------------------------------------------------------------
// One item in, one item out. After the edge that accepts the item, the block
// loads the operands (ST_LOAD), runs the two bit-serial dividers that form the
// accelerated and decelerated candidates in parallel (ST_DIV) and registers the
// candidates when they finish, then picks one and updates the state (ST_DEC)
// and returns to idle. A new item is accepted only in idle, so not before the
// last one is through, but even while the last result still waits in the output
// register; a result still waiting when the next one is ready stalls the block
// in its last step. Configuration is by the APB port: first_period at 0x0,
// idle_period at 0x4, exact_mode at 0x8.
`default_nettype none
`include "stepper_ramp_period_generator_macros.svh"

module stepper_ramp_period_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [srpg_pkg::FIELD_W-1:0]  want_period_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [srpg_pkg::FIELD_W-1:0]  step_period_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [srpg_pkg::DATA_W-1:0]   pwdata,
  output logic [srpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import srpg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DEC  = 4'b1000
  } state_e;

  localparam logic [PERIOD_WIDTH-1:0]       PMAX    = '1;
  localparam logic signed [INDEX_WIDTH-1:0] IDX_MAX = {1'b0, {(INDEX_WIDTH-1){1'b1}}};
  localparam logic signed [INDEX_WIDTH-1:0] IDX_MIN = {1'b1, {(INDEX_WIDTH-1){1'b0}}};
  localparam logic signed [INDEX_WIDTH-1:0] IDX_ONE = INDEX_WIDTH'(1);
  localparam logic signed [INDEX_WIDTH-1:0] IDX_M1  = '1;

  state_e state_q, state_d;

  logic [PERIOD_WIDTH-1:0]       first_q, idle_q;
  logic                          exact_q;
  logic [PERIOD_WIDTH-1:0]       cur_q, target_q, out_q;
  logic signed [INDEX_WIDTH-1:0] idx_q;
  logic [DIV_W-1:0]              rest_q;
  logic                          out_valid_q;

  logic [PERIOD_WIDTH-1:0]       fval_q, sval_q, fval_d, sval_d;
  logic [DIV_W-1:0]              frest_q, srest_q, frest_d, srest_d;
  logic signed [INDEX_WIDTH-1:0] fidx_q, sidx_q, sidx_d;

  logic                          cfg_wr;
  reg_idx_e                      ridx;

  logic signed [INDEX_WIDTH-1:0] idx_inc, idx_dec, n_f;
  logic [DIV_W-1:0]              d_f, d_s;
  logic [DVD_W-1:0]              twoc_w, rest_w, num_add, num_sub, kk;
  logic                          twoc_lt;
  logic [DVD_W:0]                ssum;
  logic                          idx_neg, idx_pos, slot_free, accel, decel;

  div_status_t                   fdiv_st, sdiv_st;
  logic [DVD_W-1:0]              q_f, q_s;
  logic [DIV_W-1:0]              r_f, r_s;
  logic                          div_start;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign ridx   = reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (ridx)
      REG_FIRST: prdata = DATA_W'(first_q);
      REG_IDLE:  prdata = DATA_W'(idle_q);
      REG_EXACT: prdata = DATA_W'(exact_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= PERIOD_WIDTH'(65535);
      idle_q  <= PMAX;
      exact_q <= 1'b0;
    end else if (cfg_wr) begin
      case (ridx)
        REG_FIRST: first_q <= pwdata[PERIOD_WIDTH-1:0];
        REG_IDLE:  idle_q  <= pwdata[PERIOD_WIDTH-1:0];
        REG_EXACT: exact_q <= pwdata[0];
        default:   ;
      endcase
    end
  end

  // ---------------- operands ----------------
  assign idx_inc = idx_q + IDX_ONE;
  assign idx_dec = idx_q - IDX_ONE;
  assign n_f     = (idx_q >= IDX_MAX) ? IDX_MAX : idx_inc;
  assign idx_neg = idx_q[INDEX_WIDTH-1];
  assign idx_pos = !idx_neg && (idx_q != '0);
  assign d_f     = {n_f[INDEX_WIDTH-2:0], 2'b01};
  assign d_s     = {idx_dec[INDEX_WIDTH-2:0], 2'b11};

  assign twoc_w  = DVD_W'({cur_q, 1'b0});
  assign rest_w  = DVD_W'(rest_q);
  assign num_add = twoc_w + rest_w;
  assign num_sub = twoc_w - rest_w;
  assign twoc_lt = twoc_w < rest_w;

  assign div_start = (state_q == ST_LOAD);

  srpg_div u_fdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (exact_q ? num_sub : num_add),
    .divisor_i   (d_f),
    .status_o    (fdiv_st),
    .quotient_o  (q_f),
    .remainder_o (r_f)
  );

  srpg_div u_sdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (num_add),
    .divisor_i   (d_s),
    .status_o    (sdiv_st),
    .quotient_o  (q_s),
    .remainder_o (r_s)
  );

  // ---------------- candidates ----------------
  // exact speed-up rounds the step up: k = ceil((2c - r) / d)
  assign kk   = exact_q ? (q_f + DVD_W'(r_f != '0)) : q_f;
  assign ssum = (DVD_W+1)'(cur_q) + (DVD_W+1)'(q_s);

  always_comb begin
    if (idx_neg && (idx_q != IDX_M1)) begin
      fval_d  = idle_q;
      frest_d = rest_q;
    end else if (idx_q == IDX_M1) begin
      fval_d  = first_q;
      frest_d = '0;
    end else if (exact_q && twoc_lt) begin
      fval_d  = cur_q;
      frest_d = rest_q - DIV_W'(twoc_w);
    end else begin
      fval_d  = (kk > DVD_W'(cur_q)) ? '0 : cur_q - PERIOD_WIDTH'(kk);
      if (exact_q) begin
        frest_d = (r_f == '0) ? '0 : d_f - r_f;
      end else begin
        frest_d = r_f;
      end
    end

    if (idx_pos) begin
      sval_d  = (ssum > (DVD_W+1)'(PMAX)) ? PMAX : PERIOD_WIDTH'(ssum);
      srest_d = r_s;
      sidx_d  = idx_dec;
    end else begin
      sval_d  = idle_q;
      srest_d = '0;
      sidx_d  = (idx_q == IDX_MIN) ? IDX_MIN : idx_dec;
    end
  end

  // ---------------- control ----------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign accel      = target_q < fval_q;
  assign decel      = !accel && (target_q > cur_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (fdiv_st.done) state_d = ST_DEC;
      ST_DEC:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cur_q       <= PMAX;
      idx_q       <= IDX_M1;
      rest_q      <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DEC) && slot_free) begin
        out_valid_q <= 1'b1;
        if (accel) begin
          cur_q  <= fval_q;
          idx_q  <= fidx_q;
          rest_q <= frest_q;
        end else if (decel) begin
          cur_q  <= sval_q;
          idx_q  <= sidx_q;
          rest_q <= srest_q;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      target_q <= want_period_i[PERIOD_WIDTH-1:0];
    end
    if ((state_q == ST_DIV) && fdiv_st.done) begin
      fval_q  <= fval_d;
      frest_q <= frest_d;
      fidx_q  <= n_f;
      sval_q  <= sval_d;
      srest_q <= srest_d;
      sidx_q  <= sidx_d;
    end
    if ((state_q == ST_DEC) && slot_free) begin
      if (accel) begin
        out_q <= fval_q;
      end else if (decel) begin
        out_q <= cur_q;
      end else begin
        out_q <= target_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign step_period_o = FIELD_W'(out_q);

  `SRPG_ASSERT_NEXT(a_accept_load, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_LOAD)
  `SRPG_ASSERT_SAME(a_div_lockstep, clk_i, rst_ni, 1'b1, fdiv_st == sdiv_st)
  `SRPG_ASSERT_NEXT(a_dec_emits, clk_i, rst_ni, (state_q == ST_DEC) && slot_free, out_valid_o)
  `SRPG_ASSERT_SAME(a_idle_no_div, clk_i, rst_ni, state_q == ST_IDLE, !fdiv_st.busy)

endmodule

`default_nettype wire
